/* hdl/traffic_window_average_autoscale_core_assert.svh */
// Assertion macros for the traffic window average and autoscale core.
// Included by the top level; expects clk and arst_n in scope.
`ifndef TRAFFIC_WINDOW_AVERAGE_AUTOSCALE_CORE_ASSERT_SVH
`define TRAFFIC_WINDOW_AVERAGE_AUTOSCALE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TWAA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define TWAA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/twaa_pkg.sv */
// Shared types, constants and scale table functions for the traffic window core.
// No dependencies.
`timescale 1ns / 1ps

package twaa_pkg;

	localparam int DATA_W        = 31;
	localparam int TOT_W         = 32;
	localparam int SCALE_STEPS   = 15;
	localparam int SCALE_W       = 4;
	localparam int SCALE_BYTES_W = 26;

	localparam logic [SCALE_W-1:0] SCALE_MAX_IDX = SCALE_W'(SCALE_STEPS - 1);

	// One window entry held by a cell: inbound, outbound and their total
	typedef struct packed {
		logic [DATA_W-1:0] in_bytes;
		logic [DATA_W-1:0] out_bytes;
		logic [TOT_W-1:0]  tot_bytes;
	} entry_t;

	// Chain control: shift in a new sample, or rotate the chain by one
	typedef struct packed {
		logic shift;
		logic rotate;
	} cell_ctl_t;

	// Full-scale table: 1K, 4K, 8K, ... 32768K
	function automatic logic [SCALE_BYTES_W-1:0] scale_bytes_f(input logic [SCALE_W-1:0] idx);
		logic [SCALE_BYTES_W-1:0] val;
		case (idx)
			4'd0:    val = 26'd1024;
			4'd1:    val = 26'd4096;
			4'd2:    val = 26'd8192;
			4'd3:    val = 26'd16384;
			4'd4:    val = 26'd32768;
			4'd5:    val = 26'd65536;
			4'd6:    val = 26'd131072;
			4'd7:    val = 26'd262144;
			4'd8:    val = 26'd524288;
			4'd9:    val = 26'd1048576;
			4'd10:   val = 26'd2097152;
			4'd11:   val = 26'd4194304;
			4'd12:   val = 26'd8388608;
			4'd13:   val = 26'd16777216;
			default: val = 26'd33554432;
		endcase
		return val;
	endfunction

	// First step that covers the peak, saturating at the last index
	function automatic logic [SCALE_W-1:0] pick_scale_f(input logic [TOT_W-1:0] peak);
		logic [SCALE_W-1:0] idx;
		idx = SCALE_MAX_IDX;
		for (int k = SCALE_STEPS - 2; k >= 0; k--) begin
			if (peak <= TOT_W'(scale_bytes_f(SCALE_W'(k))))
				idx = SCALE_W'(k);
		end
		return idx;
	endfunction

endpackage

/* hdl/twaa_cell.sv */
// One window cell: holds one inbound, outbound and total entry.
// Depends on twaa_pkg.
`timescale 1ns / 1ps

module twaa_cell
	import twaa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  entry_t    nbr,
	output entry_t    entry
);

	entry_t entry_q;

	// Take the neighbor's entry on a shift or a rotate step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctl.shift || ctl.rotate) begin
			entry_q <= nbr;
		end
	end

	assign entry = entry_q;

endmodule

/* hdl/twaa_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on twaa_pkg only by convention; no package items used.
`timescale 1ns / 1ps

module twaa_div #(
	parameter int N_W = 35,
	parameter int D_W = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output logic [N_W-1:0] quot,
	output logic           done
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic [N_W-1:0]   quo_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [D_W:0]     shifted;
	logic [D_W:0]     diff;
	logic             ge;

	// Trial subtract of the divisor from the shifted remainder
	always_comb begin
		shifted = {rem_q, quo_q[N_W-1]};
		diff    = shifted - {1'b0, den_q};
		ge      = (shifted >= {1'b0, den_q});
	end

	// Control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(N_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[N_W-2:0], ge};
			rem_q <= ge ? diff[D_W-1:0] : shifted[D_W-1:0];
		end
	end

	assign quot = quo_q;
	assign done = done_q;

endmodule

/* hdl/traffic_window_average_autoscale_core.sv */
// Channel | dir | tdata fields (low bit first)
// s       | in  | in_bytes[30:0], out_bytes[61:31], zero pad to 64
// m       | out | in_average[30:0], out_average[61:31], scale_index[65:62],
//         |     | scale_bytes[91:66], zero pad to 96
// One request takes one rotation of the cell chain to sum and find the
// peak, then a bit-per-cycle divide of both sums by the fill count.
// s_tready is high only while idle; a finished result waits in the output
// register and blocks the next one until taken. Reset clears the windows,
// fill count and held scale. Depends on twaa_pkg, twaa_cell, twaa_div.
`timescale 1ns / 1ps

module traffic_window_average_autoscale_core
	import twaa_pkg::*;
#(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // in_bytes[30:0], out_bytes[61:31]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata    // in_average, out_average, scale_index, scale_bytes
);

	`include "traffic_window_average_autoscale_core_assert.svh"

	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int SCAN_W = $clog2(WINDOW_DEPTH);
	localparam int SUM_W  = DATA_W + $clog2(WINDOW_DEPTH);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;
	localparam logic [1:0] ST_WRITE = 2'd3;

	logic [1:0]         state_q;
	logic [SCAN_W-1:0]  scan_q;
	logic [CNT_W-1:0]   fill_q;
	logic [SUM_W-1:0]   acc_in_q;
	logic [SUM_W-1:0]   acc_out_q;
	logic [TOT_W-1:0]   peak_q;
	logic [SCALE_W-1:0] held_q;
	logic               div_start_q;
	logic               m_tvalid_q;
	logic [95:0]        m_tdata_q;

	cell_ctl_t          ctl;
	entry_t             cell_out [WINDOW_DEPTH];
	entry_t             cell_in  [WINDOW_DEPTH];
	entry_t             new_entry;
	logic               accept;
	logic               out_free;
	logic [SUM_W-1:0]   quot_in;
	logic [SUM_W-1:0]   quot_out;
	logic               done_in;
	logic               done_out;
	logic [SCALE_W-1:0] new_scale;
	logic [SCALE_W-1:0] next_held;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	// Incoming sample as a window entry
	always_comb begin
		new_entry.in_bytes  = s_tdata[30:0];
		new_entry.out_bytes = s_tdata[61:31];
		new_entry.tot_bytes = {1'b0, s_tdata[30:0]} + {1'b0, s_tdata[61:31]};
	end

	assign ctl.shift  = accept;
	assign ctl.rotate = (state_q == ST_SCAN);

	// Cell chain: each cell takes its upper neighbor; the last takes a new
	// sample on shift, or the head entry on rotate
	genvar g;
	generate
		for (g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
			if (g == WINDOW_DEPTH - 1) begin : g_tail
				assign cell_in[g] = ctl.shift ? new_entry : cell_out[0];
			end else begin : g_body
				assign cell_in[g] = cell_out[g + 1];
			end
			twaa_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.ctl   (ctl),
				.nbr   (cell_in[g]),
				.entry (cell_out[g])
			);
		end
	endgenerate

	// Dividers for the two window means
	twaa_div #(.N_W(SUM_W), .D_W(CNT_W)) u_div_in (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start_q),
		.num   (acc_in_q),
		.den   (fill_q),
		.quot  (quot_in),
		.done  (done_in)
	);

	twaa_div #(.N_W(SUM_W), .D_W(CNT_W)) u_div_out (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start_q),
		.num   (acc_out_q),
		.den   (fill_q),
		.quot  (quot_out),
		.done  (done_out)
	);

	// Scale pick with hysteresis on the held index
	always_comb begin
		new_scale = pick_scale_f(peak_q);
		next_held = held_q;
		if (new_scale > held_q || ({1'b0, new_scale} + 5'd1) < {1'b0, held_q})
			next_held = new_scale;
	end

	// Sequencer, fill count and held scale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_q  <= '0;
			fill_q  <= '0;
			held_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						scan_q  <= '0;
						if (fill_q != CNT_W'(WINDOW_DEPTH))
							fill_q <= fill_q + 1'b1;
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == SCAN_W'(WINDOW_DEPTH - 1))
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (done_in && done_out)
						state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (out_free) begin
						held_q  <= next_held;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Divider start pulse on the last scan step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= (state_q == ST_SCAN) && (scan_q == SCAN_W'(WINDOW_DEPTH - 1));
		end
	end

	// Output valid: set on write, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_WRITE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Sum and peak accumulation over the rotating chain
	always_ff @(posedge clk) begin
		if (accept) begin
			acc_in_q  <= '0;
			acc_out_q <= '0;
			peak_q    <= '0;
		end else if (state_q == ST_SCAN) begin
			acc_in_q  <= acc_in_q + SUM_W'(cell_out[0].in_bytes);
			acc_out_q <= acc_out_q + SUM_W'(cell_out[0].out_bytes);
			if (cell_out[0].tot_bytes > peak_q)
				peak_q <= cell_out[0].tot_bytes;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE && out_free) begin
			m_tdata_q <= {4'd0, scale_bytes_f(next_held), next_held,
				quot_out[DATA_W-1:0], quot_in[DATA_W-1:0]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`TWAA_ASSERT_NXT(a_accept_scan, accept, state_q == ST_SCAN, "accept did not start a scan")
	`TWAA_ASSERT_NOW(a_fill_range, 1'b1, fill_q <= CNT_W'(WINDOW_DEPTH), "fill count over depth")
	`TWAA_ASSERT_NOW(a_held_range, 1'b1, held_q <= SCALE_MAX_IDX, "held scale out of range")
	`TWAA_ASSERT_NOW(a_div_sync, done_in || done_out, done_in && done_out, "dividers out of step")

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for traffic_window_average_autoscale_core: sends traffic samples,
// predicts the window averages and the held full scale, and checks every result in order.
// Depends on twaa_pkg and the core RTL.

module testbench;
	import twaa_pkg::*;

	localparam int DEPTH        = 16;
	localparam int CLK_PERIOD   = 8;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 64;
	localparam logic [DATA_W-1:0] FIELD_MAX = '1;

	typedef struct packed {
		logic [DATA_W-1:0]        in_average;
		logic [DATA_W-1:0]        out_average;
		logic [SCALE_W-1:0]       scale_index;
		logic [SCALE_BYTES_W-1:0] scale_bytes;
	} traffic_result_t;

	// Kinds of traffic used by the random runs
	typedef enum logic [1:0] {
		LOAD_FULL_RANGE,
		LOAD_BIT_WALK,
		LOAD_QUIET,
		LOAD_NEAR_STEP
	} load_kind_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;   // in_bytes[30:0], out_bytes[61:31]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;         // in_average, out_average, scale_index, scale_bytes

	// Predicted block state
	logic [DATA_W-1:0]  in_hist  [DEPTH];
	logic [DATA_W-1:0]  out_hist [DEPTH];
	logic [TOT_W-1:0]   tot_hist [DEPTH];
	int unsigned        fill_count = 0;
	logic [SCALE_W-1:0] held_step  = '0;

	traffic_result_t       pending_results[$];
	int unsigned           send_gap_pct    = 0;
	int unsigned           recv_gap_pct    = 0;
	int unsigned           samples_sent    = 0;
	int unsigned           results_checked = 0;
	int unsigned           error_count     = 0;
	int unsigned           cycle_count     = 0;
	logic [SCALE_STEPS-1:0] steps_seen     = '0;

	traffic_window_average_autoscale_core #(
		.WINDOW_DEPTH(DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				pending_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_gap_pct);
	end

	// Full-scale step: 1K, then 4K doubling up to 32768K
	function automatic logic [SCALE_BYTES_W-1:0] full_scale(input logic [SCALE_W-1:0] step);
		return (step == 0) ? SCALE_BYTES_W'(1024) : SCALE_BYTES_W'(32'd2048 << step);
	endfunction

	// Shift one sample into the windows and queue the result it produces
	task automatic predict_window_result(input logic [DATA_W-1:0] in_b,
			input logic [DATA_W-1:0] out_b);
		logic [37:0]        in_sum;
		logic [37:0]        out_sum;
		logic [TOT_W-1:0]   peak;
		logic [SCALE_W-1:0] step;
		traffic_result_t    res;
		in_sum  = '0;
		out_sum = '0;
		peak    = '0;
		for (int k = 0; k < DEPTH - 1; k++) begin
			in_hist[k]  = in_hist[k + 1];
			out_hist[k] = out_hist[k + 1];
			tot_hist[k] = tot_hist[k + 1];
		end
		in_hist[DEPTH - 1]  = in_b;
		out_hist[DEPTH - 1] = out_b;
		tot_hist[DEPTH - 1] = TOT_W'(in_b) + TOT_W'(out_b);
		if (fill_count < DEPTH)
			fill_count++;
		// unfilled entries are zero, so a plain sum over the window is fine
		for (int k = 0; k < DEPTH; k++) begin
			in_sum  += in_hist[k];
			out_sum += out_hist[k];
			if (tot_hist[k] > peak)
				peak = tot_hist[k];
		end
		step = '0;
		while (step < SCALE_MAX_IDX && peak > TOT_W'(full_scale(step)))
			step++;
		// hysteresis: follow a rise at once, a fall only by two steps or more
		if (step > held_step || step + 1 < held_step)
			held_step = step;
		res.in_average  = DATA_W'(in_sum / fill_count);
		res.out_average = DATA_W'(out_sum / fill_count);
		res.scale_index = held_step;
		res.scale_bytes = full_scale(held_step);
		steps_seen[held_step] = 1'b1;
		pending_results.push_back(res);
	endtask

	// Offer one request and wait until it is taken
	task automatic send_sample(input logic [DATA_W-1:0] in_b, input logic [DATA_W-1:0] out_b);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, out_b, in_b};
		do @(posedge clk); while (!s_tready);
		predict_window_result(in_b, out_b);
		samples_sent++;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	// Result checker
	always @(posedge clk) begin
		traffic_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual tdata %h",
					$time, m_tdata);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("in_average", want.in_average, m_tdata[30:0]);
				check_field("out_average", want.out_average, m_tdata[61:31]);
				check_field("scale_index", want.scale_index, m_tdata[65:62]);
				check_field("scale_bytes", want.scale_bytes, m_tdata[91:66]);
				results_checked++;
			end
		end
	end

	// Rising peak across the table edges, the corrected 256K entry and saturation
	task automatic test_scale_edges();
		send_sample('0, '0);
		send_sample(31'd1024, '0);
		send_sample('0, 31'd1025);
		send_sample(31'd131072, 31'd131072);
		send_sample(31'd131073, 31'd131072);
		send_sample(31'd16777216, 31'd16777216);
		send_sample(FIELD_MAX, FIELD_MAX);
	endtask

	// Full window one step below the top: the saturated sample ages out,
	// the fill count stops at its limit and a one-step fall is held
	task automatic test_fill_and_hold();
		for (int n = 0; n < DEPTH; n++)
			send_sample(DATA_W'(n * 1000), DATA_W'(16777216 - n * 1000));
	endtask

	// Runs of related traffic so the windows settle at levels and then move
	task automatic test_random_traffic(input int unsigned count);
		int unsigned left;
		int unsigned run_len;
		int unsigned pick;
		int unsigned total;
		int unsigned in_part;
		logic [SCALE_W-1:0] step;
		load_kind_t kind;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		left = count;
		while (left > 0) begin
			run_len = $urandom_range(1, 24);
			if (run_len > left)
				run_len = left;
			pick = $urandom_range(0, 9);
			kind = (pick < 2) ? LOAD_FULL_RANGE :
				(pick < 3) ? LOAD_BIT_WALK :
				(pick < 4) ? LOAD_QUIET : LOAD_NEAR_STEP;
			step = SCALE_W'($urandom_range(0, SCALE_MAX_IDX));
			repeat (run_len) begin
				case (kind)
					LOAD_FULL_RANGE: begin
						a = DATA_W'($urandom);
						b = DATA_W'($urandom);
					end
					LOAD_BIT_WALK: begin
						a = DATA_W'(1) << $urandom_range(0, DATA_W - 1);
						b = FIELD_MAX ^ (DATA_W'(1) << $urandom_range(0, DATA_W - 1));
						if ($urandom_range(1)) begin
							a = ~a;
							b = ~b;
						end
					end
					LOAD_QUIET: begin
						a = DATA_W'($urandom_range(0, 600));
						b = DATA_W'($urandom_range(0, 600));
					end
					default: begin
						// mostly inside the step, sometimes right on its edge
						if ($urandom_range(3) == 0)
							total = full_scale(step) + $urandom_range(0, 3) - 2;
						else
							total = full_scale(step) - $urandom_range(0, full_scale(step) / 2);
						in_part = $urandom_range(0, total);
						a = DATA_W'(in_part);
						b = DATA_W'(total - in_part);
					end
				endcase
				send_sample(a, b);
			end
			left -= run_len;
		end
	endtask

	initial begin
		for (int k = 0; k < DEPTH; k++) begin
			in_hist[k]  = '0;
			out_hist[k] = '0;
			tot_hist[k] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gap_pct = 9;
		recv_gap_pct = 81;
		test_scale_edges();
		test_fill_and_hold();
		test_random_traffic(510);

		send_gap_pct = 81;
		recv_gap_pct = 9;
		test_random_traffic(510);

		send_gap_pct = 0;
		recv_gap_pct = 0;
		test_random_traffic(510);
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d samples under three back-pressure mixes, checked %0d results.",
			samples_sent, results_checked);
		$display("Held full scale visited %0d of %0d steps.", $countones(steps_seen),
			SCALE_STEPS);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
